// ===== src/agcrf_pkg.sv =====
// Shared constants, breakpoint tables and pipeline types for the AGC to RF level interpolator.
`default_nettype none

package agcrf_pkg;

  // Breakpoint table geometry
  localparam int unsigned BREAKPOINTS = 12;
  localparam int unsigned SEGMENTS    = BREAKPOINTS - 1;
  localparam int unsigned SEG_W       = $clog2(SEGMENTS);

  // Field widths
  localparam int unsigned IN_W    = 16;
  localparam int unsigned AGC_W   = 8;
  localparam int unsigned LVL_W   = 11;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned SLOPE_W = 15;
  localparam int unsigned OFS_W   = AGC_W + 1;          // signed offset into a segment
  localparam int unsigned PROD_W  = OFS_W + SLOPE_W;
  localparam int unsigned NUM_W   = 20;                 // offset * slope + 500, signed

  // Rounding and scaling constants
  localparam int unsigned HALF_SCALE = 500;
  localparam int unsigned CODE_BASE  = 1000;

  // Divide by 1000: multiply by ceil(2^28 / 1000); exact for magnitudes up to ~490k
  localparam int unsigned RCP1K_W     = 19;
  localparam int unsigned RCP1K       = 268436;
  localparam int unsigned RCP1K_SHIFT = 28;

  // Divide by 10: multiply by ceil(2^13 / 10); exact for magnitudes below 1024
  localparam int unsigned RCP10_W     = 10;
  localparam int unsigned RCP10       = 820;
  localparam int unsigned RCP10_SHIFT = 13;

  // AGC breakpoints, strictly rising
  localparam logic [AGC_W-1:0] AGC_PTS [BREAKPOINTS] = '{
    8'd0,   8'd82,  8'd100, 8'd116, 8'd140, 8'd162,
    8'd173, 8'd187, 8'd210, 8'd223, 8'd254, 8'd255
  };

  localparam logic [AGC_W-1:0] AGC_LAST = AGC_PTS[BREAKPOINTS-1];

  // RF level at each breakpoint, 0.1 dBm
  localparam logic signed [LVL_W-1:0] LEVEL_PTS [BREAKPOINTS] = '{
    11'sd90,   -11'sd50,  -11'sd263, -11'sd361, -11'sd463, -11'sd563,
    -11'sd661, -11'sd761, -11'sd861, -11'sd891, -11'sd904, -11'sd910
  };

  // Per-segment slope: (level diff * 1000) / (AGC diff), truncated toward zero
  localparam logic signed [SLOPE_W-1:0] SLOPES [SEGMENTS] = '{
    -15'sd1707, -15'sd11833, -15'sd6125, -15'sd4250, -15'sd4545, -15'sd8909,
    -15'sd7142, -15'sd4347,  -15'sd2307, -15'sd419,  -15'sd6000
  };

  // Stage 1 -> stage 2 payload
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [LVL_W-1:0] base_level;
    logic                    sat;
  } seg_t;

  // Stage 2 -> output stage payload
  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    logic                    sat;
  } lvl_t;

endpackage

`default_nettype wire

// ===== src/agcrf_seg.sv =====
// Segment search, clamp and offset-times-slope product for one AGC reading.
`default_nettype none

module agcrf_seg (
  input  wire logic [agcrf_pkg::IN_W-1:0] agc_level_i,
  output agcrf_pkg::seg_t                 seg_o
);

  logic                                    sat;
  logic [agcrf_pkg::SEG_W-1:0]             lo;
  logic [agcrf_pkg::AGC_W-1:0]             rd;
  logic [agcrf_pkg::AGC_W-1:0]             ofs;
  logic signed [agcrf_pkg::PROD_W-1:0]     prod;

  always_comb begin
    // Reading at or past the last breakpoint is clamped to it
    sat = (agc_level_i >= agcrf_pkg::IN_W'(agcrf_pkg::AGC_LAST));

    // Lower breakpoint of the segment: last one not above the reading
    lo = '0;
    for (int i = 1; i < agcrf_pkg::SEGMENTS; i++) begin
      if (agc_level_i >= agcrf_pkg::IN_W'(agcrf_pkg::AGC_PTS[i])) begin
        lo = agcrf_pkg::SEG_W'(i);
      end
    end
    if (sat) begin
      lo = agcrf_pkg::SEG_W'(agcrf_pkg::SEGMENTS - 1);
    end

    rd   = sat ? agcrf_pkg::AGC_LAST : agc_level_i[agcrf_pkg::AGC_W-1:0];
    ofs  = rd - agcrf_pkg::AGC_PTS[lo];
    prod = $signed({1'b0, ofs}) * agcrf_pkg::SLOPES[lo];

    seg_o.num        = prod[agcrf_pkg::NUM_W-1:0]
                     + agcrf_pkg::NUM_W'(agcrf_pkg::HALF_SCALE);
    seg_o.base_level = agcrf_pkg::LEVEL_PTS[lo];
    seg_o.sat        = sat;
  end

endmodule

`default_nettype wire

// ===== src/agcrf_level.sv =====
// Scale the rounded product by 1/1000 toward zero and add the segment base level.
`default_nettype none

module agcrf_level (
  input  wire agcrf_pkg::seg_t seg_i,
  output agcrf_pkg::lvl_t      lvl_o
);

  localparam int unsigned MAG_W = agcrf_pkg::NUM_W - 1;
  localparam int unsigned MUL_W = MAG_W + agcrf_pkg::RCP1K_W;

  logic                             neg;
  logic [agcrf_pkg::NUM_W-1:0]      abs_full;
  logic [MAG_W-1:0]                 mag;
  logic [MUL_W-1:0]                 mul;
  logic [agcrf_pkg::LVL_W-1:0]      quot;
  logic [agcrf_pkg::LVL_W-1:0]      delta;

  always_comb begin
    // Truncating divide: work on the magnitude, restore the sign afterwards
    neg      = seg_i.num[agcrf_pkg::NUM_W-1];
    abs_full = neg ? -seg_i.num : seg_i.num;
    mag      = abs_full[MAG_W-1:0];
    mul      = MUL_W'(mag) * MUL_W'(agcrf_pkg::RCP1K);
    quot     = agcrf_pkg::LVL_W'(mul >> agcrf_pkg::RCP1K_SHIFT);
    delta    = neg ? -quot : quot;

    lvl_o.level = seg_i.base_level + $signed(delta);
    lvl_o.sat   = seg_i.sat;
  end

endmodule

`default_nettype wire

// ===== src/agcrf_code.sv =====
// Strength code: 1000 plus the level divided by 10, truncated toward zero.
`default_nettype none

module agcrf_code (
  input  wire logic signed [agcrf_pkg::LVL_W-1:0] level_i,
  output logic [agcrf_pkg::CODE_W-1:0]            code_o
);

  localparam int unsigned MAG_W = agcrf_pkg::LVL_W - 1;
  localparam int unsigned MUL_W = MAG_W + agcrf_pkg::RCP10_W;

  logic                              neg;
  logic [agcrf_pkg::LVL_W-1:0]       abs_full;
  logic [MAG_W-1:0]                  mag;
  logic [MUL_W-1:0]                  mul;
  logic [agcrf_pkg::CODE_W-1:0]      tenth;

  always_comb begin
    // Level magnitude stays below 1024, where the reciprocal is exact
    neg      = level_i[agcrf_pkg::LVL_W-1];
    abs_full = neg ? -level_i : level_i;
    mag      = abs_full[MAG_W-1:0];
    mul      = MUL_W'(mag) * MUL_W'(agcrf_pkg::RCP10);
    tenth    = agcrf_pkg::CODE_W'(mul >> agcrf_pkg::RCP10_SHIFT);

    code_o = neg ? agcrf_pkg::CODE_W'(agcrf_pkg::CODE_BASE) - tenth
                 : agcrf_pkg::CODE_W'(agcrf_pkg::CODE_BASE) + tenth;
  end

endmodule

`default_nettype wire

// ===== src/agc_to_rf_level_interpolator.sv =====
// Top level: AGC reading to RF level interpolator pipeline.
//
// Maps a raw AGC reading to an RF input level (0.1 dBm) by linear interpolation
// over a fixed 12-point breakpoint table, plus a strength code of 1000 + level/10.
// busy_o is always low: a request is taken on every cycle that start_i is high,
// one reading per clock. Each request yields exactly one result, shown for one
// cycle with done_o high, registered in turn through agc_q, seg_q, lvl_q and done_q;
// results leave in request order. The pipeline is input register, segment search
// and slope multiply, divide by 1000 and base add, strength code and output register.
// The receiver cannot stall the block, so it must take every done_o cycle.
// Readings of 255 and above are clamped to the last segment and flagged by
// input_saturated_o.
`default_nettype none

module agc_to_rf_level_interpolator (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic [agcrf_pkg::IN_W-1:0]            agc_level_i,
  output logic                                       done_o,
  output logic signed [agcrf_pkg::LVL_W-1:0]         level_tenths_dbm_o,
  output logic [agcrf_pkg::CODE_W-1:0]               strength_code_o,
  output logic                                       input_saturated_o
);

  logic                                 in_vld_q;
  logic [agcrf_pkg::IN_W-1:0]           agc_q;
  logic                                 s1_vld_q;
  agcrf_pkg::seg_t                      seg_d;
  agcrf_pkg::seg_t                      seg_q;
  logic                                 s2_vld_q;
  agcrf_pkg::lvl_t                      lvl_d;
  agcrf_pkg::lvl_t                      lvl_q;
  logic [agcrf_pkg::CODE_W-1:0]         code_d;
  logic                                 done_q;
  logic signed [agcrf_pkg::LVL_W-1:0]   level_q;
  logic [agcrf_pkg::CODE_W-1:0]         code_q;
  logic                                 sat_q;

  // Fully pipelined, never stalls
  assign busy_o = 1'b0;

  agcrf_seg u_seg (
    .agc_level_i (agc_q),
    .seg_o       (seg_d)
  );

  agcrf_level u_level (
    .seg_i (seg_q),
    .lvl_o (lvl_d)
  );

  agcrf_code u_code (
    .level_i (lvl_q.level),
    .code_o  (code_d)
  );

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      s1_vld_q <= in_vld_q;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q;
    end
  end

  // Payload pipeline, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      agc_q <= agc_level_i;
    end
    if (in_vld_q) begin
      seg_q <= seg_d;
    end
    if (s1_vld_q) begin
      lvl_q <= lvl_d;
    end
    if (s2_vld_q) begin
      level_q <= lvl_q.level;
      code_q  <= code_d;
      sat_q   <= lvl_q.sat;
    end
  end

  assign done_o             = done_q;
  assign level_tenths_dbm_o = level_q;
  assign strength_code_o    = code_q;
  assign input_saturated_o  = sat_q;

endmodule

`default_nettype wire
